// ===== rtl/core/first_fit_extent_allocator_assert.svh =====
// Assertion macros for the first-fit extent allocator checker
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define FFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ffa_pkg.sv =====
// Shared types, codes and field widths of the first-fit extent allocator
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int OP_W       = 2;
  localparam int SIZE_W     = 16;
  localparam int HANDLE_W   = 4;
  localparam int STATUS_W   = 2;
  localparam int ADDR_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 24;

  localparam logic [OP_W-1:0] OP_ALLOC_LOW  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_HIGH = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE       = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_GAP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ARENA_BOTTOM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_TOP    = 1'b1;

  localparam logic [ADDR_W-1:0] ARENA_BOTTOM_RST = 16'h0000;
  localparam logic [ADDR_W-1:0] ARENA_TOP_RST    = 16'hFFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_CLAIM,
    S_LINK,
    S_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic scan_clear;
    logic set_en;
    logic clr_en;
  } slot_ctl_t;

  typedef struct packed {
    logic done;
    logic full;
  } scan_stat_t;

endpackage

// ===== rtl/core/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module ffa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ffa_gap_unit.sv =====
// Shared gap test: extent end sum and fit compare used by both walk directions
`timescale 1ns / 1ps

module ffa_gap_unit (
  input  logic [ffa_pkg::ADDR_W-1:0] hi,
  input  logic [ffa_pkg::ADDR_W:0]   lo,
  input  logic [ffa_pkg::SIZE_W-1:0] size,
  input  logic [ffa_pkg::ADDR_W-1:0] base,
  input  logic [ffa_pkg::SIZE_W-1:0] len,
  output logic [ffa_pkg::ADDR_W:0]   end_sum,
  output logic [ffa_pkg::ADDR_W-1:0] top_place,
  output logic                       fit
);

  logic [ffa_pkg::ADDR_W+1:0] diff;

  assign end_sum   = {1'b0, base} + {1'b0, len};
  assign diff      = {2'b00, hi} - {2'b00, size};
  assign top_place = diff[ffa_pkg::ADDR_W-1:0];
  // a zero-length request fits any gap, even an inverted one
  assign fit       = (size == '0) ||
                     (!diff[ffa_pkg::ADDR_W+1] && (diff[ffa_pkg::ADDR_W:0] >= lo));

endmodule

// ===== rtl/core/ffa_slot_table.sv =====
// Slot valid flags with a one-slot-per-cycle scan for the lowest free slot
`timescale 1ns / 1ps

module ffa_slot_table #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ffa_pkg::slot_ctl_t              ctl,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] set_idx,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] clr_idx,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] look_idx,
  output logic                            look_valid,
  output logic [$clog2(MAX_SEGMENTS)-1:0] scan_idx,
  output ffa_pkg::scan_stat_t             stat
);

  localparam int SW = $clog2(MAX_SEGMENTS);
  localparam int IW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [IW-1:0] SCAN_END = IW'(MAX_SEGMENTS);

  logic [MAX_SEGMENTS-1:0] valid;
  logic [IW-1:0]           scan;

  assign scan_idx   = scan[SW-1:0];
  assign stat.full  = (scan == SCAN_END);
  assign stat.done  = (scan == SCAN_END) || !valid[scan_idx];
  assign look_valid = valid[look_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.set_en) begin
        valid[set_idx] <= 1'b1;
      end
      if (ctl.clr_en) begin
        valid[clr_idx] <= 1'b0;
      end
    end
  end

  // advance until a free slot or the end of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (ctl.scan_clear) begin
      scan <= '0;
    end else if (!stat.done) begin
      scan <= scan + 1'b1;
    end
  end

endmodule

// ===== rtl/core/first_fit_extent_allocator.sv =====
// Allocation walks the list entries one per cycle through the link RAMs, end of list included,
// while the slot table scans for the lowest free slot; a full slot table or no fitting gap
// ends it with a failure status. Free unlinks the handle's entry; an unallocated handle is
// refused. One operation at a time.
// Throughput: set by the list walk, one entry per cycle through the registered RAM read.
// Reset: synchronous; empties the list, marks every slot free, arena 0 to 65535; no clearing.
`timescale 1ns / 1ps

module first_fit_extent_allocator #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ffa_pkg::S_TDATA_W-1:0]      s_tdata,   // request_size, free_handle, pad
  input  logic [ffa_pkg::OP_W-1:0]           s_tuser,   // operation
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ffa_pkg::M_TDATA_W-1:0]      m_tdata,   // handle, extent_base, pad
  output logic [ffa_pkg::STATUS_W-1:0]       m_tuser    // status
);

  localparam int SW = $clog2(MAX_SEGMENTS);
  localparam int IW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [IW-1:0] NONE = IW'(MAX_SEGMENTS);
  localparam int AW = ffa_pkg::ADDR_W;
  localparam int HW = ffa_pkg::HANDLE_W;

  ffa_pkg::state_t state, state_next;

  logic [AW-1:0]              arena_bottom, arena_top;
  logic [ffa_pkg::OP_W-1:0]   op_r;
  logic [ffa_pkg::SIZE_W-1:0] size_r;
  logic [HW-1:0]              fh_r;

  logic [IW-1:0] p, p_next, prv, prv_next;
  logic [IW-1:0] prior, prior_next, after, after_next;
  logic [IW-1:0] list_first, list_first_next, list_last, list_last_next;
  logic [AW:0]   lo, lo_next;
  logic [AW-1:0] hi, hi_next, place, place_next;
  logic [SW-1:0] slot_k, slot_k_next;

  logic [ffa_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [HW-1:0]                res_handle, res_handle_next;
  logic [AW-1:0]                res_base, res_base_next;

  logic          free_rd, load_out;
  logic [SW-1:0] raddr, fh_idx, scan_idx;
  logic          seg_we;
  logic [SW-1:0] seg_waddr;
  logic          nxt_we, prv_we;
  logic [SW-1:0] nxt_waddr, prv_waddr;
  logic [IW-1:0] nxt_wdata, prv_wdata;

  logic [AW-1:0]              base_rd;
  logic [ffa_pkg::SIZE_W-1:0] len_rd;
  logic [IW-1:0]              next_rd, prev_rd;

  logic          walk_low, is_alloc, p_none, fh_in_range, look_valid;
  logic [AW-1:0] hi_sel, top_place;
  logic [AW:0]   lo_sel, end_sum;
  logic          fit;

  ffa_pkg::slot_ctl_t  ctl;
  ffa_pkg::scan_stat_t stat;

  assign s_tready    = (state == ffa_pkg::S_IDLE);
  assign walk_low    = (op_r == ffa_pkg::OP_ALLOC_LOW);
  assign is_alloc    = walk_low || (op_r == ffa_pkg::OP_ALLOC_HIGH);
  assign p_none      = (p == NONE);
  assign fh_idx      = SW'(fh_r);
  assign fh_in_range = (32'(fh_r) < MAX_SEGMENTS);
  assign raddr       = free_rd ? fh_idx : p_next[SW-1:0];

  assign hi_sel = walk_low ? (p_none ? arena_top : base_rd) : hi;
  assign lo_sel = walk_low ? lo : (p_none ? {1'b0, arena_bottom} : end_sum);

  ffa_gap_unit u_gap (
    .hi        (hi_sel),
    .lo        (lo_sel),
    .size      (size_r),
    .base      (base_rd),
    .len       (len_rd),
    .end_sum   (end_sum),
    .top_place (top_place),
    .fit       (fit)
  );

  ffa_slot_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_slots (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .set_idx    (scan_idx),
    .clr_idx    (fh_idx),
    .look_idx   (fh_idx),
    .look_valid (look_valid),
    .scan_idx   (scan_idx),
    .stat       (stat)
  );

  ffa_ram #(.WIDTH(AW), .DEPTH(MAX_SEGMENTS)) u_base_ram (
    .clk (clk), .we (seg_we), .waddr (seg_waddr), .wdata (place),
    .raddr (raddr), .rdata (base_rd)
  );

  ffa_ram #(.WIDTH(ffa_pkg::SIZE_W), .DEPTH(MAX_SEGMENTS)) u_len_ram (
    .clk (clk), .we (seg_we), .waddr (seg_waddr), .wdata (size_r),
    .raddr (raddr), .rdata (len_rd)
  );

  ffa_ram #(.WIDTH(IW), .DEPTH(MAX_SEGMENTS)) u_next_ram (
    .clk (clk), .we (nxt_we), .waddr (nxt_waddr), .wdata (nxt_wdata),
    .raddr (raddr), .rdata (next_rd)
  );

  ffa_ram #(.WIDTH(IW), .DEPTH(MAX_SEGMENTS)) u_prev_ram (
    .clk (clk), .we (prv_we), .waddr (prv_waddr), .wdata (prv_wdata),
    .raddr (raddr), .rdata (prev_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_bottom <= ffa_pkg::ARENA_BOTTOM_RST;
      arena_top    <= ffa_pkg::ARENA_TOP_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        ffa_pkg::REG_ARENA_BOTTOM: arena_bottom <= cfg_wdata;
        ffa_pkg::REG_ARENA_TOP:    arena_top    <= cfg_wdata;
        default:                   arena_top    <= arena_top;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ffa_pkg::S_IDLE;
      list_first <= NONE;
      list_last  <= NONE;
    end else begin
      state      <= state_next;
      list_first <= list_first_next;
      list_last  <= list_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r   <= s_tuser;
      size_r <= s_tdata[15:0];
      fh_r   <= s_tdata[19:16];
    end
    p          <= p_next;
    prv        <= prv_next;
    lo         <= lo_next;
    hi         <= hi_next;
    prior      <= prior_next;
    after      <= after_next;
    place      <= place_next;
    slot_k     <= slot_k_next;
    res_status <= res_status_next;
    res_handle <= res_handle_next;
    res_base   <= res_base_next;
  end

  always_comb begin
    state_next      = state;
    p_next          = p;
    prv_next        = prv;
    lo_next         = lo;
    hi_next         = hi;
    prior_next      = prior;
    after_next      = after;
    place_next      = place;
    slot_k_next     = slot_k;
    res_status_next = res_status;
    res_handle_next = res_handle;
    res_base_next   = res_base;
    list_first_next = list_first;
    list_last_next  = list_last;
    free_rd         = 1'b0;
    load_out        = 1'b0;
    ctl             = '0;
    seg_we          = 1'b0;
    seg_waddr       = scan_idx;
    nxt_we          = 1'b0;
    nxt_waddr       = '0;
    nxt_wdata       = '0;
    prv_we          = 1'b0;
    prv_waddr       = '0;
    prv_wdata       = '0;
    unique case (state)
      ffa_pkg::S_IDLE: begin
        if (s_tvalid) begin
          ctl.scan_clear = 1'b1;
          state_next     = ffa_pkg::S_START;
        end
      end
      ffa_pkg::S_START: begin
        res_status_next = ffa_pkg::ST_OK;
        res_handle_next = fh_r;
        res_base_next   = '0;
        if (is_alloc) begin
          p_next     = walk_low ? list_first : list_last;
          prv_next   = NONE;
          lo_next    = {1'b0, arena_bottom};
          hi_next    = arena_top;
          state_next = ffa_pkg::S_WALK;
        end else if (!fh_in_range || !look_valid) begin
          res_status_next = ffa_pkg::ST_BAD_HANDLE;
          state_next      = ffa_pkg::S_DONE;
        end else begin
          free_rd    = 1'b1;
          state_next = ffa_pkg::S_FREE;
        end
      end
      ffa_pkg::S_WALK: begin
        if (fit) begin
          prior_next = walk_low ? prv : p;
          after_next = walk_low ? p : prv;
          place_next = walk_low ? lo[AW-1:0] : top_place;
          state_next = ffa_pkg::S_CLAIM;
        end else if (p_none) begin
          res_status_next = ffa_pkg::ST_NO_GAP;
          state_next      = ffa_pkg::S_DONE;
        end else begin
          if (walk_low) begin
            lo_next = end_sum;
          end else begin
            hi_next = base_rd;
          end
          prv_next = p;
          p_next   = walk_low ? next_rd : prev_rd;
        end
      end
      ffa_pkg::S_CLAIM: begin
        if (stat.done) begin
          if (stat.full) begin
            res_status_next = ffa_pkg::ST_FULL;
            state_next      = ffa_pkg::S_DONE;
          end else begin
            seg_we      = 1'b1;
            nxt_we      = 1'b1;
            nxt_waddr   = scan_idx;
            nxt_wdata   = after;
            prv_we      = 1'b1;
            prv_waddr   = scan_idx;
            prv_wdata   = prior;
            ctl.set_en  = 1'b1;
            slot_k_next = scan_idx;
            state_next  = ffa_pkg::S_LINK;
          end
        end
      end
      ffa_pkg::S_LINK: begin
        if (prior == NONE) begin
          list_first_next = IW'(slot_k);
        end else begin
          nxt_we    = 1'b1;
          nxt_waddr = prior[SW-1:0];
          nxt_wdata = IW'(slot_k);
        end
        if (after == NONE) begin
          list_last_next = IW'(slot_k);
        end else begin
          prv_we    = 1'b1;
          prv_waddr = after[SW-1:0];
          prv_wdata = IW'(slot_k);
        end
        res_status_next = ffa_pkg::ST_OK;
        res_handle_next = HW'(slot_k);
        res_base_next   = place;
        state_next      = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_FREE: begin
        if (prev_rd == NONE) begin
          list_first_next = next_rd;
        end else begin
          nxt_we    = 1'b1;
          nxt_waddr = prev_rd[SW-1:0];
          nxt_wdata = next_rd;
        end
        if (next_rd == NONE) begin
          list_last_next = prev_rd;
        end else begin
          prv_we    = 1'b1;
          prv_waddr = next_rd[SW-1:0];
          prv_wdata = prev_rd;
        end
        ctl.clr_en    = 1'b1;
        res_base_next = base_rd;
        state_next    = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ffa_pkg::S_IDLE;
        end
      end
      default: state_next = ffa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {4'h0, res_base, res_handle};
      m_tuser <= res_status;
    end
  end

endmodule

// ===== rtl/core/ffa_checker.sv =====
// Port-level checker for the first-fit extent allocator, bound to the top level
`timescale 1ns / 1ps
`include "first_fit_extent_allocator_assert.svh"

module ffa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ffa_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [ffa_pkg::STATUS_W-1:0]   m_tuser
);

  `FFA_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "ready held after beat")
  `FFA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `FFA_ASSERT_SAME(a_fail_base_zero, m_tvalid && (m_tuser != ffa_pkg::ST_OK), m_tdata[19:4] == 16'h0000, "failed result with nonzero base")
  `FFA_ASSERT_SAME(a_result_from_busy, $rose(m_tvalid), $past(!s_tready), "result without operation in flight")

endmodule

bind first_fit_extent_allocator ffa_checker u_ffa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
